// ===== rtl/vfm_pkg.sv =====
// vfm_pkg: shared types, codes and tables of the voxel face mesher.
// No dependencies; imported by every module of the block.
`default_nettype none

package vfm_pkg;

    // Default chunk dimensions
    localparam int unsigned VFM_WIDTH_X  = 16;
    localparam int unsigned VFM_LENGTH_Z = 16;
    localparam int unsigned VFM_HEIGHT_Y = 256;

    // Request types
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_EDGE = 2'd1;
    localparam logic [1:0] REQ_MESH = 2'd2;

    // Neighbour edge sides
    localparam logic [1:0] SIDE_NEGX = 2'd0;
    localparam logic [1:0] SIDE_POSX = 2'd1;
    localparam logic [1:0] SIDE_NEGZ = 2'd2;
    localparam logic [1:0] SIDE_POSZ = 2'd3;

    // Face codes
    localparam logic [2:0] FACE_NEGX = 3'd0;
    localparam logic [2:0] FACE_POSX = 3'd1;
    localparam logic [2:0] FACE_NEGZ = 3'd2;
    localparam logic [2:0] FACE_POSZ = 3'd3;
    localparam logic [2:0] FACE_NEGY = 3'd4;
    localparam logic [2:0] FACE_POSY = 3'd5;

    // Probe steps: center voxel, then neighbours in face test order
    localparam logic [2:0] STEP_CENTER = 3'd0;
    localparam logic [2:0] STEP_POSY   = 3'd1;
    localparam logic [2:0] STEP_NEGY   = 3'd2;
    localparam logic [2:0] STEP_POSZ   = 3'd3;
    localparam logic [2:0] STEP_NEGZ   = 3'd4;
    localparam logic [2:0] STEP_POSX   = 3'd5;
    localparam logic [2:0] STEP_NEGX   = 3'd6;

    // Last corner of a face in emit order
    localparam logic [1:0] CORNER_LAST = 2'd3;
    localparam logic [1:0] CODE_TOP_LEFT = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_TEST,
        ST_EMIT
    } state_t;

    // Store write controls
    typedef struct packed {
        logic chunk_we;
        logic edge_we;
        logic edge_wdata;
    } store_wr_t;

    // Corner offset {dx,dz,dy} of a face, corners in emit order
    function automatic logic [2:0] corner_ofs(input logic [2:0] face, input logic [1:0] c);
        logic [11:0] row;
        case (face)
            FACE_NEGX: row = {3'b001, 3'b011, 3'b010, 3'b000};
            FACE_POSX: row = {3'b111, 3'b101, 3'b100, 3'b110};
            FACE_NEGZ: row = {3'b000, 3'b100, 3'b101, 3'b001};
            FACE_POSZ: row = {3'b011, 3'b111, 3'b110, 3'b010};
            FACE_NEGY: row = {3'b010, 3'b110, 3'b100, 3'b000};
            FACE_POSY: row = {3'b001, 3'b101, 3'b111, 3'b011};
            default:   row = '0;
        endcase
        return row[c*3 +: 3];
    endfunction

    // Corner code: bottomLeft, bottomRight, topRight, topLeft
    function automatic logic [1:0] corner_code(input logic [1:0] c);
        return {c[1], c[1] ^ c[0]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vfm_store.sv =====
// vfm_store: chunk voxel memory and neighbour edge memory, registered reads.
// Runs the clearing sweep after reset. Depends on vfm_pkg.
`default_nettype none

module vfm_store
    import vfm_pkg::*;
#(
    parameter int unsigned CHUNK_AW = 16,
    parameter int unsigned EDGE_AW  = 14
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire store_wr_t           wr,
    input  wire logic [CHUNK_AW-1:0] chunk_waddr,
    input  wire logic [7:0]          chunk_wdata,
    input  wire logic [EDGE_AW-1:0]  edge_waddr,
    input  wire logic [CHUNK_AW-1:0] chunk_raddr,
    input  wire logic [EDGE_AW-1:0]  edge_raddr,
    output logic      [7:0]          chunk_rdata,
    output logic                     edge_rdata,
    output logic                     clearing
);

    localparam int unsigned CLR_W = (CHUNK_AW > EDGE_AW) ? CHUNK_AW : EDGE_AW;

    logic [7:0] chunk_mem [2**CHUNK_AW];
    logic       edge_mem  [2**EDGE_AW];

    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clearing_reg, clearing_next;
    logic [7:0]       chunk_rdata_reg;
    logic             edge_rdata_reg;

    // Clearing sweep: one address of each memory per cycle
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == '1)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    // Chunk memory
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            chunk_mem[clr_cnt_reg[CHUNK_AW-1:0]] <= '0;
        end
        else if (wr.chunk_we)
        begin
            chunk_mem[chunk_waddr] <= chunk_wdata;
        end
        chunk_rdata_reg <= chunk_mem[chunk_raddr];
    end

    // Edge memory
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            edge_mem[clr_cnt_reg[EDGE_AW-1:0]] <= 1'b0;
        end
        else if (wr.edge_we)
        begin
            edge_mem[edge_waddr] <= wr.edge_wdata;
        end
        edge_rdata_reg <= edge_mem[edge_raddr];
    end

    assign chunk_rdata = chunk_rdata_reg;
    assign edge_rdata  = edge_rdata_reg;
    assign clearing    = clearing_reg;

endmodule

`default_nettype wire

// ===== rtl/vfm_vertex.sv =====
// vfm_vertex: corner offset adders and vertex word packing.
// Depends on vfm_pkg (corner tables).
`default_nettype none

module vfm_vertex
    import vfm_pkg::*;
(
    input  wire logic [4:0]  vox_x,
    input  wire logic [4:0]  vox_z,
    input  wire logic [8:0]  vox_y,
    input  wire logic [7:0]  vox_id,
    input  wire logic [2:0]  face,
    input  wire logic [1:0]  corner,
    output logic      [31:0] word
);

    logic [2:0] ofs;
    logic [4:0] vx, vz;
    logic [8:0] vy;

    // Corner position, then packing
    always_comb
    begin
        ofs  = corner_ofs(face, corner);
        vx   = vox_x + {4'd0, ofs[2]};
        vz   = vox_z + {4'd0, ofs[1]};
        vy   = vox_y + {8'd0, ofs[0]};
        word = {corner_code(corner), face, vox_id, vy, vz, vx};
    end

endmodule

`default_nettype wire

// ===== rtl/voxel_face_mesher.sv =====
// voxel_face_mesher: face-culling mesher for one chunk, with a neighbour edge store.
// Top level: sequencer, output register. Depends on vfm_pkg, vfm_store, vfm_vertex.
`default_nettype none

// After reset the block clears both stores, one address per cycle, sweeping
// 2**max(chunk_aw, edge_aw) addresses (65536 at the default 16x16x256 chunk), with
// req_stall high. A voxel load, an edge load or a mesh request with a coordinate
// out of range is done on acceptance and leaves the block idle. A mesh request
// reads the voxel through the single read port of the stores (ST_FETCH, then
// ST_TEST) and ends there if the voxel is air. Otherwise it goes on to probe the
// six neighbours, each in a ST_FETCH and a ST_TEST state, then emits one vertex
// word per cycle through the output register while vert_stall does not hold it:
// four words per open face, skipping each closed face ahead of the last open one.
// req_stall stays high until the last word is in the output register.
module voxel_face_mesher
    import vfm_pkg::*;
#(
    parameter int unsigned WIDTH_X  = VFM_WIDTH_X,
    parameter int unsigned LENGTH_Z = VFM_LENGTH_Z,
    parameter int unsigned HEIGHT_Y = VFM_HEIGHT_Y
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [3:0]  pos_x,
    input  wire logic [3:0]  pos_z,
    input  wire logic [7:0]  pos_y,
    input  wire logic [7:0]  block_id,
    input  wire logic [1:0]  side,
    output logic             vert_valid,
    input  wire logic        vert_stall,
    output logic [31:0]      vertex_word,
    output logic             last_in_run
);

    localparam int unsigned XW = $clog2(WIDTH_X);
    localparam int unsigned ZW = $clog2(LENGTH_Z);
    localparam int unsigned YW = $clog2(HEIGHT_Y);
    localparam int unsigned AW = (XW > ZW) ? XW : ZW;
    localparam int unsigned CHUNK_AW = XW + ZW + YW;
    localparam int unsigned EDGE_AW  = 2 + YW + AW;

    localparam logic [4:0] LIM_X = 5'(WIDTH_X);
    localparam logic [4:0] LIM_Z = 5'(LENGTH_Z);
    localparam logic [8:0] LIM_Y = 9'(HEIGHT_Y);
    localparam logic [XW-1:0] MAX_X = XW'(WIDTH_X - 1);
    localparam logic [ZW-1:0] MAX_Z = ZW'(LENGTH_Z - 1);
    localparam logic [YW-1:0] MAX_Y = YW'(HEIGHT_Y - 1);

    state_t            state_reg, state_next;
    logic [2:0]        step_reg, step_next;
    logic [XW-1:0]     x_reg, x_next;
    logic [ZW-1:0]     z_reg, z_next;
    logic [YW-1:0]     y_reg, y_next;
    logic [7:0]        id_reg, id_next;
    logic [5:0]        open_reg, open_next;
    logic              use_edge_reg, use_edge_next;
    logic              closed_reg, closed_next;
    logic [2:0]        face_reg, face_next;
    logic [1:0]        corner_reg, corner_next;
    logic              vert_valid_reg, vert_valid_next;
    logic [31:0]       word_reg, word_next;
    logic              last_reg, last_next;

    store_wr_t         wr;
    logic [CHUNK_AW-1:0] chunk_waddr, chunk_raddr;
    logic [EDGE_AW-1:0]  edge_waddr, edge_raddr;
    logic [7:0]        chunk_rdata;
    logic              edge_rdata;
    logic              clearing;

    logic              accept;
    logic              in_range;
    logic [3:0]        edge_a;
    logic              edge_in_range;
    logic [XW-1:0]     nx;
    logic [ZW-1:0]     nz;
    logic [YW-1:0]     ny;
    logic [1:0]        probe_side;
    logic [AW-1:0]     probe_a;
    logic              probe_bit;
    logic              out_free;
    logic              last_word;
    logic [2:0]        face_code;
    logic [31:0]       vert_word;

    assign accept   = req_valid && !req_stall;
    assign out_free = !vert_valid_reg || !vert_stall;

    // Range checks and write addresses of load transactions
    always_comb
    begin
        in_range = ({1'b0, pos_x} < LIM_X) && ({1'b0, pos_z} < LIM_Z)
                   && ({1'b0, pos_y} < LIM_Y);
        if (side == SIDE_NEGX || side == SIDE_POSX)
        begin
            edge_a        = pos_z;
            edge_in_range = ({1'b0, pos_z} < LIM_Z) && ({1'b0, pos_y} < LIM_Y);
        end
        else
        begin
            edge_a        = pos_x;
            edge_in_range = ({1'b0, pos_x} < LIM_X) && ({1'b0, pos_y} < LIM_Y);
        end
        chunk_waddr   = {pos_y[YW-1:0], pos_z[ZW-1:0], pos_x[XW-1:0]};
        edge_waddr    = {side, pos_y[YW-1:0], edge_a[AW-1:0]};
        wr.chunk_we   = accept && (req_type == REQ_LOAD) && in_range;
        wr.edge_we    = accept && (req_type == REQ_EDGE) && edge_in_range;
        wr.edge_wdata = (block_id != 8'd0);
    end

    // Neighbour probe address for the current step
    always_comb
    begin
        nx            = x_reg;
        nz            = z_reg;
        ny            = y_reg;
        probe_side    = SIDE_NEGX;
        probe_a       = AW'(z_reg);
        use_edge_next = 1'b0;
        closed_next   = 1'b0;
        case (step_reg)
            STEP_POSY:
            begin
                ny          = y_reg + 1'b1;
                closed_next = (y_reg == MAX_Y);
            end
            STEP_NEGY:
            begin
                ny          = y_reg - 1'b1;
                closed_next = (y_reg == '0);
            end
            STEP_POSZ:
            begin
                nz            = z_reg + 1'b1;
                probe_side    = SIDE_POSZ;
                probe_a       = AW'(x_reg);
                use_edge_next = (z_reg == MAX_Z);
            end
            STEP_NEGZ:
            begin
                nz            = z_reg - 1'b1;
                probe_side    = SIDE_NEGZ;
                probe_a       = AW'(x_reg);
                use_edge_next = (z_reg == '0);
            end
            STEP_POSX:
            begin
                nx            = x_reg + 1'b1;
                probe_side    = SIDE_POSX;
                use_edge_next = (x_reg == MAX_X);
            end
            STEP_NEGX:
            begin
                nx            = x_reg - 1'b1;
                probe_side    = SIDE_NEGX;
                use_edge_next = (x_reg == '0);
            end
            default:
            begin
            end
        endcase
        chunk_raddr = {ny, nz, nx};
        edge_raddr  = {probe_side, y_reg, probe_a};
    end

    // Open test of the probed neighbour
    assign probe_bit = !closed_reg && (use_edge_reg ? !edge_rdata : (chunk_rdata == 8'd0));

    // Emit: faces in test order, face code counts down from +y
    assign face_code = FACE_POSY - face_reg;
    assign last_word = (corner_reg == CORNER_LAST)
                       && ((open_reg & ~(6'd1 << face_reg)) == 6'd0);

    vfm_vertex u_vertex (
        .vox_x  ({{(5 - XW){1'b0}}, x_reg}),
        .vox_z  ({{(5 - ZW){1'b0}}, z_reg}),
        .vox_y  ({{(9 - YW){1'b0}}, y_reg}),
        .vox_id (id_reg),
        .face   (face_code),
        .corner (corner_reg),
        .word   (vert_word)
    );

    vfm_store #(
        .CHUNK_AW (CHUNK_AW),
        .EDGE_AW  (EDGE_AW)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (wr),
        .chunk_waddr (chunk_waddr),
        .chunk_wdata (block_id),
        .edge_waddr  (edge_waddr),
        .chunk_raddr (chunk_raddr),
        .edge_raddr  (edge_raddr),
        .chunk_rdata (chunk_rdata),
        .edge_rdata  (edge_rdata),
        .clearing    (clearing)
    );

    // Sequencer next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        x_next          = x_reg;
        z_next          = z_reg;
        y_next          = y_reg;
        id_next         = id_reg;
        open_next       = open_reg;
        face_next       = face_reg;
        corner_next     = corner_reg;
        vert_valid_next = vert_valid_reg && vert_stall;
        word_next       = word_reg;
        last_next       = last_reg;
        req_stall       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!clearing)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_MESH) && in_range)
                begin
                    x_next     = pos_x[XW-1:0];
                    z_next     = pos_z[ZW-1:0];
                    y_next     = pos_y[YW-1:0];
                    step_next  = STEP_CENTER;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (step_reg == STEP_CENTER)
                begin
                    id_next   = chunk_rdata;
                    open_next = 6'd0;
                    step_next = STEP_POSY;
                    state_next = (chunk_rdata == 8'd0) ? ST_IDLE : ST_FETCH;
                end
                else
                begin
                    open_next = {probe_bit, open_reg[5:1]};
                    step_next = step_reg + 1'b1;
                    if (step_reg == STEP_NEGX)
                    begin
                        face_next   = 3'd0;
                        corner_next = 2'd0;
                        state_next  = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_EMIT:
            begin
                if (open_reg == 6'd0)
                begin
                    state_next = ST_IDLE;
                end
                else if (!open_reg[face_reg])
                begin
                    face_next   = face_reg + 1'b1;
                    corner_next = 2'd0;
                end
                else if (out_free)
                begin
                    vert_valid_next = 1'b1;
                    word_next       = vert_word;
                    last_next       = last_word;
                    corner_next     = corner_reg + 1'b1;
                    if (corner_reg == CORNER_LAST)
                    begin
                        open_next[face_reg] = 1'b0;
                        face_next           = face_reg + 1'b1;
                    end
                    if (last_word)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            step_reg       <= STEP_CENTER;
            open_reg       <= '0;
            face_reg       <= '0;
            corner_reg     <= '0;
            vert_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            open_reg       <= open_next;
            face_reg       <= face_next;
            corner_reg     <= corner_next;
            vert_valid_reg <= vert_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        z_reg        <= z_next;
        y_reg        <= y_next;
        id_reg       <= id_next;
        use_edge_reg <= use_edge_next;
        closed_reg   <= closed_next;
        word_reg     <= word_next;
        last_reg     <= last_next;
    end

    assign vert_valid  = vert_valid_reg;
    assign vertex_word = word_reg;
    assign last_in_run = last_reg;

`ifndef ASSERT_OFF
    // No word leaves before the clearing sweep is over
    a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !vert_valid)
        else $error("vertex word during clearing sweep");

    // Face field only carries one of the six face codes
    a_face_code: assert property (@(posedge clk) disable iff (!rst_n)
        vert_valid |-> (vertex_word[29:27] <= FACE_POSY))
        else $error("bad face code in vertex word");

    // The final word of a run closes a face, on the topLeft corner
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (vert_valid && last_in_run) |-> (vertex_word[31:30] == CODE_TOP_LEFT))
        else $error("last_in_run on a corner other than topLeft");

    // A new word is only loaded while emitting
    a_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (vert_valid && !$past(vert_valid && vert_stall)) |-> ($past(state_reg) == ST_EMIT))
        else $error("vertex word loaded outside emit");
`endif

endmodule

`default_nettype wire
